// File: src/round_robin_thread_scheduler_assert.svh
// Assertion macros for the round-robin thread scheduler.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define RRTS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rrts assertion failed");
// Checked at every edge, reset included.
`define RRTS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rrts assertion failed");
`else
`define RRTS_ASSERT(lbl, clk, rst, prop)
`define RRTS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: src/rrts_pkg.sv
// Types and codes shared by the round-robin thread scheduler.
`default_nettype none
package rrts_pkg;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  thread_id;
      logic [15:0] sleep_quanta;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value;
      logic [3:0]  running_id;
      logic        switched;
      logic [31:0] total_count;
   } rsp_type;

   localparam logic [2:0] KIND_TICK      = 3'd0;
   localparam logic [2:0] KIND_SPAWN     = 3'd1;
   localparam logic [2:0] KIND_TERMINATE = 3'd2;
   localparam logic [2:0] KIND_BLOCK     = 3'd3;
   localparam logic [2:0] KIND_RESUME    = 3'd4;
   localparam logic [2:0] KIND_SLEEP     = 3'd5;
   localparam logic [2:0] KIND_QUERY     = 3'd6;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NO_THREAD = 3'd1;
   localparam logic [2:0] STATUS_FULL      = 3'd2;
   localparam logic [2:0] STATUS_MAIN      = 3'd3;
   localparam logic [2:0] STATUS_EXIT      = 3'd4;
   localparam logic [2:0] STATUS_NO_READY  = 3'd5;

   localparam logic [1:0] MODE_RUNNING = 2'd0;
   localparam logic [1:0] MODE_READY   = 2'd1;
   localparam logic [1:0] MODE_BLOCKED = 2'd2;

   localparam logic [23:0] QLEN_RESET = 24'd1000;

   // thread table word: sleep count over quantum count
   localparam int TWORD_WIDTH = 48;

endpackage
`default_nettype wire

// File: src/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler.
//
//   channel  direction  handshake          payload
//   req_     in         req_valid/stall    rrts_pkg::req_type
//   rsp_     out        rsp_valid/stall    rrts_pkg::rsp_type
//   csr_     in         csr_wr_en          quantum length, 24 bits
//
// Simple items go through decode, then result load. A quantum expiry
// walks every id, with one thread-table update per sleeping thread.
// Block or terminate of a queued thread scans and compacts the ready-queue RAM;
// spawn scans ids for the lowest free one.
// Reset is synchronous; all flags clear at once, no clearing pass.
// A stalled result sits in the output register while the next item runs.
`default_nettype none
module round_robin_thread_scheduler #(
   parameter int MAX_THREADS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rrts_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rrts_pkg::rsp_type     rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [23:0]      csr_wr_data
);
   localparam int IW = $clog2(MAX_THREADS);
   localparam int QW = IW + 1;
   localparam int TW = rrts_pkg::TWORD_WIDTH;
   localparam logic [QW-1:0] MAXQ = QW'(MAX_THREADS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SPAWN, ST_EXP_SCAN, ST_EXP_UPD, ST_PREEMPT, ST_SN_RD,
      ST_SN_ID, ST_SN_WB, ST_REM_RD, ST_REM_CMP, ST_SHIFT, ST_SHIFT_WR,
      ST_SLP_WB, ST_QRY, ST_DONE
   } state_type;

   // queue ring pointer arithmetic
   function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] a,
                                              input logic [QW-1:0] b);
      logic [QW-1:0] s;
      s = QW'(a) + b;
      if (s >= MAXQ) s = s - MAXQ;
      return s[IW-1:0];
   endfunction

   function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] a);
      return (QW'(a) == MAXQ - QW'(1)) ? '0 : a + IW'(1);
   endfunction

   state_type state_ff, state_in;

   // per-thread flags in flops
   logic [MAX_THREADS-1:0] used_ff, used_in;
   logic [MAX_THREADS-1:0] sleeping_ff, sleeping_in;
   logic [MAX_THREADS-1:0] ublk_ff, ublk_in;
   logic [MAX_THREADS-1:0] tvalid_ff, tvalid_in;   // thread table entry written
   logic [1:0] mode_ff [MAX_THREADS];
   logic [1:0] mode_in [MAX_THREADS];

   logic [IW-1:0] head_ff, head_in;
   logic [QW-1:0] count_ff, count_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [31:0]   total_ff, total_in;
   logic [23:0]   time_left_ff, time_left_in;
   logic [23:0]   qlen_ff, qlen_in;

   // per-item working registers
   logic [QW-1:0] idx_ff, idx_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [IW-1:0] target_ff, target_in;
   logic [IW-1:0] trsel_ff, trsel_in;
   logic [2:0]    status_ff, status_in;
   logic [31:0]   value_ff, value_in;
   logic          sw_ff, sw_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rrts_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // RAM ports
   logic          q_we, q_re;
   logic [IW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;
   logic          t_we, t_re;
   logic [IW-1:0] t_waddr, t_raddr;
   logic [TW-1:0] t_wdata, t_rdata;

   // current thread is live and holds the core
   logic          cur_live;

   rrts_ram #(.WIDTH(IW), .DEPTH(MAX_THREADS)) u_queue_ram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_en(q_re), .rd_addr(q_raddr), .rd_data(q_rdata)
   );

   rrts_ram #(.WIDTH(TW), .DEPTH(MAX_THREADS)) u_thread_ram (
      .clock(clock), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
      .rd_en(t_re), .rd_addr(t_raddr), .rd_data(t_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign cur_live  = used_ff[cur_ff] && (mode_ff[cur_ff] == rrts_pkg::MODE_RUNNING);

   always_comb begin
      logic [31:0]   tid32;
      logic [IW-1:0] tid;
      logic          exists;
      logic          is_cur;
      logic [IW-1:0] tail;
      logic [IW-1:0] ix;
      logic [TW-1:0] tword;
      logic [15:0]   sl;
      tid32  = 32'(req_data.thread_id);
      tid    = tid32[IW-1:0];
      exists = (tid32 < 32'(MAX_THREADS)) && used_ff[tid];
      is_cur = (tid32 < 32'(MAX_THREADS)) && (tid == cur_ff);
      tail   = ring_add(head_ff, count_ff);
      ix     = idx_ff[IW-1:0];
      // entry never written reads as zero
      tword  = tvalid_ff[trsel_ff] ? t_rdata : '0;
      sl     = tword[TW-1:32] - 16'd1;

      state_in     = state_ff;
      used_in      = used_ff;
      sleeping_in  = sleeping_ff;
      ublk_in      = ublk_ff;
      tvalid_in    = tvalid_ff;
      mode_in      = mode_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      total_in     = total_ff;
      time_left_in = time_left_ff;
      qlen_in      = csr_wr_en ? csr_wr_data : qlen_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      target_in    = target_ff;
      trsel_in     = trsel_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      sw_in        = sw_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      q_we = 1'b0; q_waddr = tail; q_wdata = '0;
      q_re = 1'b0; q_raddr = head_ff;
      t_we = 1'b0; t_waddr = trsel_ff; t_wdata = '0;
      t_re = 1'b0; t_raddr = trsel_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               status_in = rrts_pkg::STATUS_OK;
               value_in  = '0;
               sw_in     = 1'b0;
               state_in  = ST_DONE;
               unique case (req_data.kind)
                  rrts_pkg::KIND_TICK: begin
                     if (time_left_ff <= 24'd1) begin
                        idx_in   = '0;
                        state_in = ST_EXP_SCAN;
                     end else begin
                        time_left_in = time_left_ff - 24'd1;
                     end
                  end
                  rrts_pkg::KIND_SPAWN: begin
                     idx_in   = '0;
                     state_in = ST_SPAWN;
                  end
                  rrts_pkg::KIND_TERMINATE: begin
                     if (!exists) begin
                        status_in = rrts_pkg::STATUS_NO_THREAD;
                     end else if (req_data.thread_id == 4'd0 ||
                                  (is_cur && count_ff == '0)) begin
                        // process exit: back to power-up state
                        status_in    = rrts_pkg::STATUS_EXIT;
                        used_in      = MAX_THREADS'(1);
                        sleeping_in  = '0;
                        ublk_in      = '0;
                        tvalid_in    = '0;
                        for (int i = 0; i < MAX_THREADS; i++)
                           mode_in[i] = rrts_pkg::MODE_READY;
                        mode_in[0]   = rrts_pkg::MODE_RUNNING;
                        head_in      = '0;
                        count_in     = '0;
                        cur_in       = '0;
                        total_in     = 32'd1;
                        time_left_in = qlen_ff;
                     end else begin
                        sleeping_in[tid] = 1'b0;
                        ublk_in[tid]     = 1'b0;
                        used_in[tid]     = 1'b0;
                        tvalid_in[tid]   = 1'b0;
                        mode_in[tid]     = rrts_pkg::MODE_READY;
                        if (is_cur) begin
                           state_in = ST_SN_RD;
                        end else begin
                           target_in = tid;
                           ptr_in    = head_ff;
                           idx_in    = '0;
                           state_in  = ST_REM_RD;
                        end
                     end
                  end
                  rrts_pkg::KIND_BLOCK: begin
                     if (req_data.thread_id == 4'd0) begin
                        status_in = rrts_pkg::STATUS_MAIN;
                     end else if (!exists) begin
                        status_in = rrts_pkg::STATUS_NO_THREAD;
                     end else if (mode_ff[tid] == rrts_pkg::MODE_BLOCKED) begin
                        ublk_in[tid] = 1'b1;
                     end else if (is_cur) begin
                        if (count_ff == '0) begin
                           status_in = rrts_pkg::STATUS_NO_READY;
                        end else begin
                           mode_in[tid] = rrts_pkg::MODE_BLOCKED;
                           ublk_in[tid] = 1'b1;
                           state_in     = ST_SN_RD;
                        end
                     end else begin
                        mode_in[tid] = rrts_pkg::MODE_BLOCKED;
                        ublk_in[tid] = 1'b1;
                        target_in    = tid;
                        ptr_in       = head_ff;
                        idx_in       = '0;
                        state_in     = ST_REM_RD;
                     end
                  end
                  rrts_pkg::KIND_RESUME: begin
                     if (!exists) begin
                        status_in = rrts_pkg::STATUS_NO_THREAD;
                     end else if (mode_ff[tid] == rrts_pkg::MODE_BLOCKED) begin
                        ublk_in[tid] = 1'b0;
                        if (!sleeping_ff[tid] && count_ff < MAXQ) begin
                           mode_in[tid] = rrts_pkg::MODE_READY;
                           q_we         = 1'b1;
                           q_wdata      = tid;
                           count_in     = count_ff + QW'(1);
                        end else if (!sleeping_ff[tid]) begin
                           mode_in[tid] = rrts_pkg::MODE_READY;
                        end
                     end
                  end
                  rrts_pkg::KIND_SLEEP: begin
                     if (cur_ff == '0 && req_data.sleep_quanta != 16'd0) begin
                        status_in = rrts_pkg::STATUS_MAIN;
                     end else if (req_data.sleep_quanta == 16'd0) begin
                        state_in = ST_PREEMPT;   // yield
                     end else if (count_ff == '0) begin
                        status_in = rrts_pkg::STATUS_NO_READY;
                     end else begin
                        sleeping_in[cur_ff] = 1'b1;
                        mode_in[cur_ff]     = rrts_pkg::MODE_BLOCKED;
                        value_in            = 32'(req_data.sleep_quanta);
                        t_re                = 1'b1;
                        t_raddr             = cur_ff;
                        trsel_in            = cur_ff;
                        state_in            = ST_SLP_WB;
                     end
                  end
                  rrts_pkg::KIND_QUERY: begin
                     if (!exists) begin
                        status_in = rrts_pkg::STATUS_NO_THREAD;
                     end else begin
                        t_re     = 1'b1;
                        t_raddr  = tid;
                        trsel_in = tid;
                        state_in = ST_QRY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SPAWN: begin
            // lowest free id, one id a cycle
            if (idx_ff == MAXQ) begin
               status_in = rrts_pkg::STATUS_FULL;
               state_in  = ST_DONE;
            end else if (!used_ff[ix]) begin
               used_in[ix]     = 1'b1;
               mode_in[ix]     = rrts_pkg::MODE_READY;
               tvalid_in[ix]   = 1'b0;
               sleeping_in[ix] = 1'b0;
               ublk_in[ix]     = 1'b0;
               if (count_ff < MAXQ) begin
                  q_we     = 1'b1;
                  q_wdata  = ix;
                  count_in = count_ff + QW'(1);
               end
               value_in = 32'(idx_ff);
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + QW'(1);
            end
         end
         ST_EXP_SCAN: begin
            if (idx_ff == MAXQ) begin
               state_in = ST_PREEMPT;
            end else if (sleeping_ff[ix]) begin
               t_re     = 1'b1;
               t_raddr  = ix;
               trsel_in = ix;
               state_in = ST_EXP_UPD;
            end else begin
               idx_in = idx_ff + QW'(1);
            end
         end
         ST_EXP_UPD: begin
            t_we               = 1'b1;
            t_wdata            = {sl, tword[31:0]};
            tvalid_in[trsel_ff] = 1'b1;
            if (sl == 16'd0) begin
               sleeping_in[trsel_ff] = 1'b0;
               if (!ublk_ff[trsel_ff]) begin
                  mode_in[trsel_ff] = rrts_pkg::MODE_READY;
                  if (count_ff < MAXQ) begin
                     q_we     = 1'b1;
                     q_wdata  = trsel_ff;
                     count_in = count_ff + QW'(1);
                  end
               end
            end
            idx_in   = idx_ff + QW'(1);
            state_in = ST_EXP_SCAN;
         end
         ST_PREEMPT: begin
            mode_in[cur_ff] = rrts_pkg::MODE_READY;
            if (count_ff < MAXQ) begin
               q_we     = 1'b1;
               q_wdata  = cur_ff;
               count_in = count_ff + QW'(1);
            end
            state_in = ST_SN_RD;
         end
         ST_SN_RD: begin
            q_re     = 1'b1;
            q_raddr  = head_ff;
            state_in = ST_SN_ID;
         end
         ST_SN_ID: begin
            head_in          = ring_inc(head_ff);
            count_in         = count_ff - QW'(1);
            cur_in           = q_rdata;
            mode_in[q_rdata] = rrts_pkg::MODE_RUNNING;
            t_re             = 1'b1;
            t_raddr          = q_rdata;
            trsel_in         = q_rdata;
            state_in         = ST_SN_WB;
         end
         ST_SN_WB: begin
            t_we                = 1'b1;
            t_wdata             = {tword[TW-1:32], tword[31:0] + 32'd1};
            tvalid_in[trsel_ff] = 1'b1;
            total_in            = total_ff + 32'd1;
            time_left_in        = qlen_ff;
            sw_in               = 1'b1;
            value_in            = '0;
            state_in            = ST_DONE;
         end
         ST_REM_RD: begin
            if (idx_ff >= count_ff) begin
               state_in = ST_DONE;
            end else begin
               q_re     = 1'b1;
               q_raddr  = ptr_ff;
               state_in = ST_REM_CMP;
            end
         end
         ST_REM_CMP: begin
            if (q_rdata == target_ff) begin
               state_in = ST_SHIFT;
            end else begin
               ptr_in   = ring_inc(ptr_ff);
               idx_in   = idx_ff + QW'(1);
               state_in = ST_REM_RD;
            end
         end
         ST_SHIFT: begin
            // pull later entries one place toward the front
            if (idx_ff + QW'(1) < count_ff) begin
               q_re     = 1'b1;
               q_raddr  = ring_inc(ptr_ff);
               state_in = ST_SHIFT_WR;
            end else begin
               count_in = count_ff - QW'(1);
               state_in = ST_DONE;
            end
         end
         ST_SHIFT_WR: begin
            q_we     = 1'b1;
            q_waddr  = ptr_ff;
            q_wdata  = q_rdata;
            ptr_in   = ring_inc(ptr_ff);
            idx_in   = idx_ff + QW'(1);
            state_in = ST_SHIFT;
         end
         ST_SLP_WB: begin
            t_we                = 1'b1;
            t_wdata             = {value_ff[15:0], tword[31:0]};
            tvalid_in[trsel_ff] = 1'b1;
            state_in            = ST_SN_RD;
         end
         ST_QRY: begin
            value_in = tword[31:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.value       = value_ff;
               rsp_data_in.running_id  = 4'(cur_ff);
               rsp_data_in.switched    = sw_ff;
               rsp_data_in.total_count = total_ff;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= MAX_THREADS'(1);
         sleeping_ff  <= '0;
         ublk_ff      <= '0;
         tvalid_ff    <= '0;
         for (int i = 0; i < MAX_THREADS; i++)
            mode_ff[i] <= (i == 0) ? rrts_pkg::MODE_RUNNING : rrts_pkg::MODE_READY;
         head_ff      <= '0;
         count_ff     <= '0;
         cur_ff       <= '0;
         total_ff     <= 32'd1;
         time_left_ff <= rrts_pkg::QLEN_RESET;
         qlen_ff      <= rrts_pkg::QLEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         sleeping_ff  <= sleeping_in;
         ublk_ff      <= ublk_in;
         tvalid_ff    <= tvalid_in;
         mode_ff      <= mode_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         total_ff     <= total_in;
         time_left_ff <= time_left_in;
         qlen_ff      <= qlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      ptr_ff      <= ptr_in;
      target_ff   <= target_in;
      trsel_ff    <= trsel_in;
      status_ff   <= status_in;
      value_ff    <= value_in;
      sw_ff       <= sw_in;
      rsp_data_ff <= rsp_data_in;
   end

`include "round_robin_thread_scheduler_assert.svh"

   // queue never holds more than the thread table
   `RRTS_ASSERT(a_count_bound, clock, reset, count_ff <= MAXQ)
   // between items the current thread is live and running
   `RRTS_ASSERT(a_cur_running, clock, reset, (state_ff == ST_IDLE) |-> cur_live)
   // thread 0 never leaves the table
   `RRTS_ASSERT(a_main_used, clock, reset, used_ff[0])
   // reset restores the quantum total and clears the result valid
   `RRTS_ASSERT_ALWAYS(a_reset_total, clock, reset |=> (total_ff == 32'd1 && !rsp_valid_ff))

endmodule
`default_nettype wire

// File: src/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: dv/round_robin_thread_scheduler_test.sv
// Self-checking testbench for the round-robin thread scheduler.
`timescale 1ns / 1ps
module round_robin_thread_scheduler_test;

   localparam int          THREADS     = 16;
   localparam int          STALL_LIMIT = 20000;
   localparam int          DRAIN_WAIT  = 200;
   localparam logic [2:0]  KIND_UNUSED = 3'd7;

   typedef struct {
      rrts_pkg::req_type req;
      bit                fixed;    // expectation typed in, not predicted
      rrts_pkg::rsp_type want;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   rrts_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rrts_pkg::rsp_type rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [23:0]       csr_wr_data = '0;

   // travels with req_data so the monitor knows which expectation to queue
   bit                drv_fixed = 1'b0;
   rrts_pkg::rsp_type drv_want = '0;

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          mismatches = 0;
   int          items_sent = 0;
   int          items_back = 0;
   int          switch_count = 0;
   int          exit_count = 0;
   int          quiet_cycles = 0;

   // shadow scheduler state
   logic [23:0] qlen_shadow;
   logic [23:0] ticks_left;
   bit          slot_used [THREADS];
   logic [1:0]  mode [THREADS];
   logic [31:0] quanta [THREADS];
   logic [15:0] sleep_left [THREADS];
   bit          asleep [THREADS];
   bit          user_blk [THREADS];
   logic [3:0]  ready_q [$];
   logic [3:0]  running;
   logic [31:0] quanta_total;

   rrts_pkg::rsp_type expected_rsp [$];
   dir_row_type       dir_table [$];

   round_robin_thread_scheduler u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- shadow model

   // back to the power-up picture; the quantum register is kept
   task automatic clear_threads();
      for (int i = 0; i < THREADS; i++) begin
         slot_used[i]  = 1'b0;
         mode[i]       = rrts_pkg::MODE_READY;
         quanta[i]     = '0;
         sleep_left[i] = '0;
         asleep[i]     = 1'b0;
         user_blk[i]   = 1'b0;
      end
      slot_used[0] = 1'b1;
      mode[0]      = rrts_pkg::MODE_RUNNING;
      ready_q.delete();
      running      = '0;
      quanta_total = 32'd1;
      ticks_left   = qlen_shadow;
   endtask

   task automatic enqueue(logic [3:0] id);
      if (ready_q.size() < THREADS) ready_q = {ready_q, id};
   endtask

   task automatic dequeue_id(logic [3:0] id);
      foreach (ready_q[i]) begin
         if (ready_q[i] == id) begin
            ready_q.delete(i);
            break;
         end
      end
   endtask

   // front of the queue takes the core and a fresh quantum
   task automatic run_next();
      logic [3:0] id;
      id = ready_q[0];
      ready_q.delete(0);
      running      = id;
      mode[id]     = rrts_pkg::MODE_RUNNING;
      quanta[id]   = quanta[id] + 32'd1;
      quanta_total = quanta_total + 32'd1;
      ticks_left   = qlen_shadow;
   endtask

   task automatic rotate();
      mode[running] = rrts_pkg::MODE_READY;
      enqueue(running);
      run_next();
   endtask

   task automatic schedule_step(input rrts_pkg::req_type r, output rrts_pkg::rsp_type o);
      logic [2:0]  st;
      logic [31:0] val;
      bit          sw;
      st  = rrts_pkg::STATUS_OK;
      val = '0;
      sw  = 1'b0;
      case (r.kind)
         rrts_pkg::KIND_TICK: begin
            if (ticks_left <= 24'd1) begin
               // expiry: wake sleepers in id order, then preempt
               for (int i = 0; i < THREADS; i++) begin
                  if (asleep[i]) begin
                     sleep_left[i] = sleep_left[i] - 16'd1;
                     if (sleep_left[i] == 16'd0) begin
                        asleep[i] = 1'b0;
                        if (!user_blk[i]) begin
                           mode[i] = rrts_pkg::MODE_READY;
                           enqueue(i[3:0]);
                        end
                     end
                  end
               end
               rotate();
               sw = 1'b1;
            end else begin
               ticks_left = ticks_left - 24'd1;
            end
         end
         rrts_pkg::KIND_SPAWN: begin
            st = rrts_pkg::STATUS_FULL;
            for (int i = 0; i < THREADS; i++) begin
               if (!slot_used[i]) begin
                  slot_used[i]  = 1'b1;
                  mode[i]       = rrts_pkg::MODE_READY;
                  quanta[i]     = '0;
                  sleep_left[i] = '0;
                  asleep[i]     = 1'b0;
                  user_blk[i]   = 1'b0;
                  enqueue(i[3:0]);
                  st  = rrts_pkg::STATUS_OK;
                  val = 32'(i);
                  break;
               end
            end
         end
         rrts_pkg::KIND_TERMINATE: begin
            if (!slot_used[r.thread_id]) begin
               st = rrts_pkg::STATUS_NO_THREAD;
            end else if (r.thread_id == 4'd0 ||
                         (r.thread_id == running && ready_q.size() == 0)) begin
               st = rrts_pkg::STATUS_EXIT;
               clear_threads();
            end else begin
               dequeue_id(r.thread_id);
               asleep[r.thread_id]     = 1'b0;
               sleep_left[r.thread_id] = '0;
               user_blk[r.thread_id]   = 1'b0;
               slot_used[r.thread_id]  = 1'b0;
               mode[r.thread_id]       = rrts_pkg::MODE_READY;
               if (r.thread_id == running) begin
                  run_next();
                  sw = 1'b1;
               end
            end
         end
         rrts_pkg::KIND_BLOCK: begin
            if (r.thread_id == 4'd0) begin
               st = rrts_pkg::STATUS_MAIN;
            end else if (!slot_used[r.thread_id]) begin
               st = rrts_pkg::STATUS_NO_THREAD;
            end else if (mode[r.thread_id] == rrts_pkg::MODE_BLOCKED) begin
               user_blk[r.thread_id] = 1'b1;
            end else if (r.thread_id == running) begin
               if (ready_q.size() == 0) begin
                  st = rrts_pkg::STATUS_NO_READY;
               end else begin
                  mode[r.thread_id]     = rrts_pkg::MODE_BLOCKED;
                  user_blk[r.thread_id] = 1'b1;
                  run_next();
                  sw = 1'b1;
               end
            end else begin
               mode[r.thread_id]     = rrts_pkg::MODE_BLOCKED;
               user_blk[r.thread_id] = 1'b1;
               dequeue_id(r.thread_id);
            end
         end
         rrts_pkg::KIND_RESUME: begin
            if (!slot_used[r.thread_id]) begin
               st = rrts_pkg::STATUS_NO_THREAD;
            end else if (mode[r.thread_id] == rrts_pkg::MODE_BLOCKED) begin
               user_blk[r.thread_id] = 1'b0;
               if (!asleep[r.thread_id]) begin
                  mode[r.thread_id] = rrts_pkg::MODE_READY;
                  enqueue(r.thread_id);
               end
            end
         end
         rrts_pkg::KIND_SLEEP: begin
            if (running == 4'd0 && r.sleep_quanta != 16'd0) begin
               st = rrts_pkg::STATUS_MAIN;
            end else if (r.sleep_quanta == 16'd0) begin
               rotate();
               sw = 1'b1;
            end else if (ready_q.size() == 0) begin
               st = rrts_pkg::STATUS_NO_READY;
            end else begin
               sleep_left[running] = r.sleep_quanta;
               asleep[running]     = 1'b1;
               mode[running]       = rrts_pkg::MODE_BLOCKED;
               run_next();
               sw = 1'b1;
            end
         end
         rrts_pkg::KIND_QUERY: begin
            if (!slot_used[r.thread_id]) st = rrts_pkg::STATUS_NO_THREAD;
            else val = quanta[r.thread_id];
         end
         default: ;
      endcase
      o.status      = st;
      o.value       = val;
      o.running_id  = running;
      o.switched    = sw;
      o.total_count = quanta_total;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rrts_pkg::rsp_type p;
      rrts_pkg::rsp_type e;
      rrts_pkg::rsp_type w;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            schedule_step(req_data, p);
            e = drv_fixed ? drv_want : p;
            expected_rsp = {expected_rsp, e};
         end
         if (rsp_valid && !rsp_stall) begin
            items_back++;
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected item", 32'd1, 32'd0);
            end else begin
               w = expected_rsp[0];
               expected_rsp.delete(0);
               if (rsp_data.status != w.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(w.status));
               if (rsp_data.value != w.value)
                  report_mismatch("value", rsp_data.value, w.value);
               if (rsp_data.running_id != w.running_id)
                  report_mismatch("running_id", 32'(rsp_data.running_id),
                                  32'(w.running_id));
               if (rsp_data.switched != w.switched)
                  report_mismatch("switched", 32'(rsp_data.switched), 32'(w.switched));
               if (rsp_data.total_count != w.total_count)
                  report_mismatch("total_count", rsp_data.total_count, w.total_count);
               if (w.switched) switch_count++;
               if (w.status == rrts_pkg::STATUS_EXIT) exit_count++;
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_item(rrts_pkg::req_type r, bit fixed, rrts_pkg::rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      drv_fixed <= fixed;
      drv_want  <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      while (expected_rsp.size() != 0) @(negedge clock);
   endtask

   // only while idle: every result is back and the block has settled
   task automatic write_quantum(logic [23:0] v);
      req_valid <= 1'b0;
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      qlen_shadow = v;
   endtask

   function automatic rrts_pkg::req_type mk(logic [2:0] k, logic [3:0] id, logic [15:0] n);
      rrts_pkg::req_type r;
      r.kind         = k;
      r.thread_id    = id;
      r.sleep_quanta = n;
      return r;
   endfunction

   function automatic rrts_pkg::rsp_type ans(logic [2:0] st, logic [31:0] v,
                                             logic [31:0] tot);
      rrts_pkg::rsp_type o;
      o.status      = st;
      o.value       = v;
      o.running_id  = '0;
      o.switched    = 1'b0;
      o.total_count = tot;
      return o;
   endfunction

   function automatic dir_row_type row(rrts_pkg::req_type r);
      dir_row_type d;
      d.req   = r;
      d.fixed = 1'b0;
      d.want  = '0;
      return d;
   endfunction

   function automatic dir_row_type row_fixed(rrts_pkg::req_type r, rrts_pkg::rsp_type w);
      dir_row_type d;
      d.req   = r;
      d.fixed = 1'b1;
      d.want  = w;
      return d;
   endfunction

   task automatic add_row(dir_row_type d);
      dir_table = {dir_table, d};
   endtask

   // mostly legal traffic on random thread ids, some noise and odd codes
   function automatic rrts_pkg::req_type random_req();
      rrts_pkg::req_type r;
      int unsigned       pick;
      pick = $urandom_range(99);
      r.thread_id    = 4'($urandom_range(15));
      r.sleep_quanta = 16'($urandom_range(4));
      if (pick < 38)      r.kind = rrts_pkg::KIND_TICK;
      else if (pick < 52) r.kind = rrts_pkg::KIND_SPAWN;
      else if (pick < 62) r.kind = rrts_pkg::KIND_TERMINATE;
      else if (pick < 71) r.kind = rrts_pkg::KIND_BLOCK;
      else if (pick < 82) r.kind = rrts_pkg::KIND_RESUME;
      else if (pick < 93) r.kind = rrts_pkg::KIND_SLEEP;
      else if (pick < 98) r.kind = rrts_pkg::KIND_QUERY;
      else                r.kind = KIND_UNUSED;
      // main-thread terminate resets everything; keep it rare
      if (r.kind == rrts_pkg::KIND_TERMINATE && r.thread_id == 4'd0 &&
          $urandom_range(7) != 0)
         r.thread_id = 4'($urandom_range(1, 15));
      if ($urandom_range(19) == 0) r.sleep_quanta = 16'($urandom);
      return r;
   endfunction

   task automatic random_phase(int count, int s_idle, int r_idle);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      repeat (count) send_item(random_req(), 1'b0, '0);
   endtask

   initial begin
      qlen_shadow = rrts_pkg::QLEN_RESET;
      clear_threads();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // quantum of 1: every tick expires, so sleep and wake show up quickly
      write_quantum(24'd1);

      add_row(row_fixed(mk(rrts_pkg::KIND_QUERY, 4'd0, 16'd0),
                        ans(rrts_pkg::STATUS_OK, 32'd0, 32'd1)));
      add_row(row_fixed(mk(rrts_pkg::KIND_QUERY, 4'd15, 16'hFFFF),
                        ans(rrts_pkg::STATUS_NO_THREAD, 32'd0, 32'd1)));
      add_row(row_fixed(mk(rrts_pkg::KIND_BLOCK, 4'd0, 16'd0),
                        ans(rrts_pkg::STATUS_MAIN, 32'd0, 32'd1)));
      add_row(row_fixed(mk(rrts_pkg::KIND_SLEEP, 4'd0, 16'd5),
                        ans(rrts_pkg::STATUS_MAIN, 32'd0, 32'd1)));
      add_row(row_fixed(mk(rrts_pkg::KIND_SPAWN, 4'd0, 16'd0),
                        ans(rrts_pkg::STATUS_OK, 32'd1, 32'd1)));
      add_row(row(mk(rrts_pkg::KIND_SLEEP, 4'd0, 16'd0)));     // yield
      add_row(row(mk(rrts_pkg::KIND_SPAWN, 4'd0, 16'd0)));
      add_row(row(mk(rrts_pkg::KIND_SPAWN, 4'd0, 16'd0)));
      add_row(row(mk(rrts_pkg::KIND_TICK, 4'd0, 16'd0)));
      add_row(row(mk(rrts_pkg::KIND_SLEEP, 4'd0, 16'd3)));
      add_row(row(mk(rrts_pkg::KIND_BLOCK, 4'd2, 16'd0)));     // queued thread
      add_row(row(mk(rrts_pkg::KIND_BLOCK, 4'd2, 16'd0)));     // already blocked
      add_row(row(mk(rrts_pkg::KIND_BLOCK, 4'd1, 16'd0)));     // queued thread
      add_row(row(mk(rrts_pkg::KIND_TICK, 4'd0, 16'd0)));
      add_row(row(mk(rrts_pkg::KIND_RESUME, 4'd1, 16'd0)));    // blocked, not asleep
      add_row(row(mk(rrts_pkg::KIND_TICK, 4'd0, 16'd0)));
      add_row(row(mk(rrts_pkg::KIND_TICK, 4'd0, 16'd0)));
      add_row(row(mk(rrts_pkg::KIND_RESUME, 4'd2, 16'd0)));
      add_row(row(mk(rrts_pkg::KIND_RESUME, 4'd0, 16'd0)));    // not blocked
      add_row(row(mk(rrts_pkg::KIND_RESUME, 4'd9, 16'd0)));
      add_row(row(mk(rrts_pkg::KIND_TERMINATE, 4'd9, 16'd0)));
      add_row(row(mk(KIND_UNUSED, 4'd15, 16'hFFFF)));
      add_row(row(mk(rrts_pkg::KIND_SLEEP, 4'd0, 16'hFFFF)));
      add_row(row(mk(rrts_pkg::KIND_TERMINATE, 4'd3, 16'd0)));
      add_row(row_fixed(mk(rrts_pkg::KIND_TERMINATE, 4'd0, 16'd0),
                        ans(rrts_pkg::STATUS_EXIT, 32'd0, 32'd1)));

      send_idle_pct = 8;
      recv_idle_pct = 79;
      foreach (dir_table[i])
         send_item(dir_table[i].req, dir_table[i].fixed, dir_table[i].want);

      // zero quantum behaves as one
      write_quantum(24'd0);
      random_phase(350, 8, 79);
      write_quantum(24'd3);
      random_phase(350, 79, 8);
      // longest quantum: no expiry, only explicit switches
      write_quantum(24'hFFFFFF);
      random_phase(150, 0, 0);
      write_quantum(24'd2);
      random_phase(350, 0, 0);

      req_valid <= 1'b0;
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d items, checked %0d results over quantum lengths 1, 0, 3, max and 2.",
               items_sent, items_back);
      $display("Saw %0d context switches and %0d process exits.", switch_count, exit_count);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/rrts_pkg.sv
src/rrts_ram.sv
src/round_robin_thread_scheduler.sv
dv/round_robin_thread_scheduler_test.sv
